// ===== design/xid_pkg.sv =====
// ----------------------------------------------------------------------------
// xid_pkg: shared types and helpers of the 16-bit x86 instruction decoder
// Holds the encoding classes, the record layout and the opcode helper
// functions used by the byte collector and the field decoder.
// ----------------------------------------------------------------------------
package xid_pkg;

    localparam int MAX_INSTR_BYTES = 6;
    localparam int COUNT_W = 3;

    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_CMP = 5'd2;
    localparam logic [4:0] OP_MOV = 5'd3;
    localparam logic [4:0] OP_JCC_BASE = 5'd4;
    localparam logic [4:0] OP_LOOP_BASE = 5'd20;
    localparam logic [4:0] OP_OTHER = 5'd24;

    localparam logic KIND_REG_DST = 1'b0;
    localparam logic KIND_MEM_DST = 1'b1;
    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_MEM = 2'd1;
    localparam logic [1:0] KIND_IMM = 2'd2;
    localparam logic [3:0] CODE_DIRECT = 4'd8;

    localparam logic [2:0] SUB_ADD = 3'd0;
    localparam logic [2:0] SUB_SUB = 3'd5;
    localparam logic [2:0] SUB_CMP = 3'd7;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT = 3'd6;

    typedef enum logic [2:0] {
        OPC_BAD,
        OPC_RM,
        OPC_ACC_IMMED,
        OPC_REG_IMMED,
        OPC_RM_IMMED,
        OPC_GROUP1,
        OPC_JUMP
    } enc_t;

    typedef struct packed {
        logic                                valid;
        logic                                bad;
        logic [COUNT_W-1:0]                  length;
        logic [MAX_INSTR_BYTES-1:0][7:0]     bytes;
    } instr_t;

    typedef struct packed {
        logic [4:0]         op_kind;
        logic               is_word;
        logic               dst_kind;
        logic [3:0]         dst_code;
        logic [1:0]         src_kind;
        logic [3:0]         src_code;
        logic [15:0]        mem_disp;
        logic [15:0]        imm_value;
        logic               imm_signed;
        logic signed [7:0]  jump_disp;
        logic               bad_opcode;
        logic [2:0]         instr_length;
    } record_t;

    function automatic enc_t classify(input logic [7:0] op);
        enc_t enc;
        enc = OPC_BAD;
        if (op[7:3] inside {5'h00, 5'h05, 5'h07}) begin
            if (op[2:0] inside {[3'd0:3'd3]})
                enc = OPC_RM;
            else if (op[2:0] inside {3'd4, 3'd5})
                enc = OPC_ACC_IMMED;
            else
                enc = OPC_BAD;
        end
        else if (op inside {[8'h88:8'h8B]})
            enc = OPC_RM;
        else if (op inside {[8'h70:8'h7F], [8'hE0:8'hE3]})
            enc = OPC_JUMP;
        else if (op inside {[8'h80:8'h83]})
            enc = OPC_GROUP1;
        else if (op inside {[8'hB0:8'hBF]})
            enc = OPC_REG_IMMED;
        else if (op inside {8'hC6, 8'hC7})
            enc = OPC_RM_IMMED;
        return enc;
    endfunction

    function automatic logic [4:0] base_kind(input logic [7:0] op);
        logic [4:0] kind;
        case (op[7:3])
            5'h00:   kind = OP_ADD;
            5'h05:   kind = OP_SUB;
            5'h07:   kind = OP_CMP;
            default: kind = OP_MOV;
        endcase
        return kind;
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] len;
        case (modrm[7:6])
            MOD_NODISP: len = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            MOD_DISP8:  len = 2'd1;
            MOD_DISP16: len = 2'd2;
            default:    len = 2'd0;
        endcase
        return len;
    endfunction

    function automatic logic is_wide(input enc_t enc, input logic [7:0] op);
        return (enc == OPC_REG_IMMED) ? op[3] : op[0];
    endfunction

    function automatic logic [1:0] imm_len(input enc_t enc, input logic [7:0] op);
        logic w;
        w = is_wide(enc, op);
        if (enc == OPC_GROUP1 && w && op[1])
            return 2'd1;
        return w ? 2'd2 : 2'd1;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

// ===== design/xid_ifs.sv =====
// ----------------------------------------------------------------------------
// xid_ifs: channel interfaces of the instruction decoder
// The byte stream channel and the decoded record channel, each with a
// valid/ready handshake and its payload.
// ----------------------------------------------------------------------------
interface xid_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] instr_byte;

    modport source (output valid, output instr_byte, input ready);
    modport sink (input valid, input instr_byte, output ready);
endinterface

interface xid_record_if;
    logic               valid;
    logic               ready;
    logic [4:0]         op_kind;
    logic               is_word;
    logic               dst_kind;
    logic [3:0]         dst_code;
    logic [1:0]         src_kind;
    logic [3:0]         src_code;
    logic [15:0]        mem_disp;
    logic [15:0]        imm_value;
    logic               imm_signed;
    logic signed [7:0]  jump_disp;
    logic               bad_opcode;
    logic [2:0]         instr_length;

    modport source (
        output valid, output op_kind, output is_word, output dst_kind,
        output dst_code, output src_kind, output src_code, output mem_disp,
        output imm_value, output imm_signed, output jump_disp,
        output bad_opcode, output instr_length, input ready
    );
    modport sink (
        input valid, input op_kind, input is_word, input dst_kind,
        input dst_code, input src_kind, input src_code, input mem_disp,
        input imm_value, input imm_signed, input jump_disp,
        input bad_opcode, input instr_length, output ready
    );
endinterface

// ===== design/xid_collect.sv =====
// ----------------------------------------------------------------------------
// xid_collect: instruction byte collector
// Gathers the bytes of the current instruction, works out its length from
// the opcode and mod-reg-r/m byte, and flags complete or bad instructions.
// ----------------------------------------------------------------------------
module xid_collect
    import xid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] instr_byte,
    output instr_t     instr
);

    logic [MAX_INSTR_BYTES-1:0][7:0] bytes_reg;
    logic [MAX_INSTR_BYTES-1:0][7:0] bytes_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] need_reg;
    logic [COUNT_W-1:0] need_next;
    logic [COUNT_W-1:0] slot;
    logic [COUNT_W-1:0] new_count;
    logic [COUNT_W-1:0] need_cur;
    logic [COUNT_W-1:0] need_new;
    logic               wrapped;
    logic               bad;
    logic               complete;
    enc_t               enc_byte;
    enc_t               enc_first;

    always_comb
    begin
        wrapped = (count_reg >= COUNT_W'(MAX_INSTR_BYTES));
        slot = wrapped ? '0 : count_reg;
        need_cur = wrapped ? '0 : need_reg;
        new_count = slot + COUNT_W'(1);

        bytes_next = bytes_reg;
        bytes_next[slot] = instr_byte;

        enc_byte = classify(instr_byte);
        enc_first = classify(bytes_next[0]);

        bad = 1'b0;
        need_new = need_cur;
        if (new_count == COUNT_W'(1))
        begin
            if (enc_byte == OPC_BAD)
                bad = 1'b1;
            else if (enc_byte == OPC_JUMP)
                need_new = COUNT_W'(2);
            else if (enc_byte == OPC_ACC_IMMED || enc_byte == OPC_REG_IMMED)
                need_new = COUNT_W'(1) + COUNT_W'(imm_len(enc_byte, instr_byte));
            else
                need_new = '0;
        end
        else if (new_count == COUNT_W'(2) && need_cur == '0)
        begin
            need_new = COUNT_W'(2) + COUNT_W'(disp_len(instr_byte));
            if (enc_first == OPC_RM_IMMED || enc_first == OPC_GROUP1)
                need_new = need_new + COUNT_W'(imm_len(enc_first, bytes_next[0]));
        end

        complete = !bad && need_new != '0 && new_count >= need_new;

        if (bad || complete)
        begin
            count_next = '0;
            need_next = '0;
        end
        else
        begin
            count_next = new_count;
            need_next = need_new;
        end

        instr.valid = fire && (bad || complete);
        instr.bad = bad;
        instr.length = new_count;
        instr.bytes = bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            need_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
            need_reg <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            bytes_reg <= bytes_next;
    end

endmodule

// ===== design/xid_decode.sv =====
// ----------------------------------------------------------------------------
// xid_decode: instruction field decoder
// Turns the collected bytes of one complete instruction into the operand,
// displacement and immediate fields of a decoded record.
// ----------------------------------------------------------------------------
module xid_decode
    import xid_pkg::*;
(
    input  instr_t  instr,
    output record_t rec
);

    logic [7:0]  op;
    logic [7:0]  b2;
    enc_t        enc;
    logic        w;
    logic [1:0]  md;
    logic [2:0]  rm;
    logic [2:0]  reg_field;
    logic [1:0]  dl;
    logic        rm_kind;
    logic [3:0]  rm_code;
    logic [15:0] disp;
    logic [2:0]  imm_at;
    logic [7:0]  imm_lo;
    logic [7:0]  imm_hi;

    always_comb
    begin
        op = instr.bytes[0];
        b2 = instr.bytes[1];
        enc = classify(op);
        w = is_wide(enc, op);
        md = b2[7:6];
        rm = b2[2:0];
        reg_field = b2[5:3];
        dl = disp_len(b2);
        rm_kind = (md != 2'd3);
        rm_code = (md == MOD_NODISP && rm == RM_DIRECT) ? CODE_DIRECT : {1'b0, rm};
        disp = '0;
        if (rm_kind)
        begin
            if (dl == 2'd1)
                disp = sext8(instr.bytes[2]);
            else if (dl == 2'd2)
                disp = {instr.bytes[3], instr.bytes[2]};
        end
        imm_at = 3'd2 + {1'b0, dl};
        imm_lo = instr.bytes[imm_at];
        imm_hi = instr.bytes[3'(imm_at + 3'd1)];

        rec = '0;
        rec.instr_length = instr.length;

        if (instr.bad)
        begin
            rec.bad_opcode = 1'b1;
            rec.instr_length = 3'd1;
        end
        else if (enc == OPC_JUMP)
        begin
            if (op[7:4] == 4'h7)
                rec.op_kind = OP_JCC_BASE + {1'b0, op[3:0]};
            else
                rec.op_kind = OP_LOOP_BASE + {3'b0, op[1:0]};
            rec.jump_disp = b2;
        end
        else if (enc == OPC_ACC_IMMED || enc == OPC_REG_IMMED)
        begin
            rec.op_kind = base_kind(op);
            rec.is_word = w;
            rec.dst_code = (enc == OPC_REG_IMMED) ? {1'b0, op[2:0]} : 4'd0;
            rec.src_kind = KIND_IMM;
            rec.imm_value = w ? {instr.bytes[2], b2} : {8'h00, b2};
        end
        else
        begin
            rec.is_word = w;
            rec.mem_disp = disp;
            if (enc == OPC_RM)
            begin
                rec.op_kind = base_kind(op);
                if (op[1])
                begin
                    rec.dst_kind = KIND_REG_DST;
                    rec.dst_code = {1'b0, reg_field};
                    rec.src_kind = rm_kind ? KIND_MEM : KIND_REG;
                    rec.src_code = rm_code;
                end
                else
                begin
                    rec.dst_kind = rm_kind ? KIND_MEM_DST : KIND_REG_DST;
                    rec.dst_code = rm_code;
                    rec.src_kind = KIND_REG;
                    rec.src_code = {1'b0, reg_field};
                end
            end
            else
            begin
                rec.dst_kind = rm_kind ? KIND_MEM_DST : KIND_REG_DST;
                rec.dst_code = rm_code;
                rec.src_kind = KIND_IMM;
                if (enc == OPC_GROUP1)
                begin
                    case (reg_field)
                        SUB_ADD: rec.op_kind = OP_ADD;
                        SUB_SUB: rec.op_kind = OP_SUB;
                        SUB_CMP: rec.op_kind = OP_CMP;
                        default: rec.op_kind = OP_OTHER;
                    endcase
                end
                else
                begin
                    rec.op_kind = OP_MOV;
                end
                if (enc == OPC_GROUP1 && w && op[1])
                begin
                    rec.imm_value = sext8(imm_lo);
                    rec.imm_signed = 1'b1;
                end
                else if (w)
                begin
                    rec.imm_value = {imm_hi, imm_lo};
                end
                else
                begin
                    rec.imm_value = {8'h00, imm_lo};
                end
            end
        end
    end

endmodule

// ===== design/x86_16_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// x86_16_instruction_decoder: 8086 instruction decoder, subset
// Accepts an instruction stream one byte per request and returns one decoded
// record for each complete instruction or unsupported opcode.
// ----------------------------------------------------------------------------
// Usage:
// The stream channel takes one instruction byte per request. The record
// channel returns one decoded record when the last byte of an instruction
// has arrived, or at once for an unsupported first byte, which is dropped.
// Bytes that do not finish an instruction produce no record.
// The block takes one byte every cycle while the result register is free or
// its record is being taken; the rate is set by the input byte register and
// the result register, with the byte collector and the field decoder between
// them. A record is registered from the last byte held in the input register.
// While a record waits in the result register, one more byte can be held in
// the input register; further requests stall only while both are occupied.
// Reset clears the collected length state and empties both registers.
// ----------------------------------------------------------------------------
module x86_16_instruction_decoder
    import xid_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    xid_stream_if.sink    stream,
    xid_record_if.source  record
);

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       res_valid_reg;
    record_t    res_reg;
    logic       out_free;
    logic       fire;
    instr_t     instr;
    record_t    rec;

    assign out_free = !res_valid_reg || record.ready;
    assign fire = byte_valid_reg && out_free;
    assign stream.ready = !byte_valid_reg || out_free;

    xid_collect u_collect (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .instr_byte (byte_reg),
        .instr      (instr)
    );

    xid_decode u_decode (
        .instr (instr),
        .rec   (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (stream.valid && stream.ready)
                byte_valid_reg <= 1'b1;
            else if (fire)
                byte_valid_reg <= 1'b0;

            if (instr.valid)
                res_valid_reg <= 1'b1;
            else if (record.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
            byte_reg <= stream.instr_byte;
        if (instr.valid)
            res_reg <= rec;
    end

    assign record.valid = res_valid_reg;
    assign record.op_kind = res_reg.op_kind;
    assign record.is_word = res_reg.is_word;
    assign record.dst_kind = res_reg.dst_kind;
    assign record.dst_code = res_reg.dst_code;
    assign record.src_kind = res_reg.src_kind;
    assign record.src_code = res_reg.src_code;
    assign record.mem_disp = res_reg.mem_disp;
    assign record.imm_value = res_reg.imm_value;
    assign record.imm_signed = res_reg.imm_signed;
    assign record.jump_disp = res_reg.jump_disp;
    assign record.bad_opcode = res_reg.bad_opcode;
    assign record.instr_length = res_reg.instr_length;

endmodule
